FILE: rtl/online_pixel_cluster_energy_core_defines.svh
// assertion macros for the cluster energy core
`ifndef ONLINE_PIXEL_CLUSTER_ENERGY_CORE_DEFINES_SVH
`define ONLINE_PIXEL_CLUSTER_ENERGY_CORE_DEFINES_SVH

// condition that must never be seen at a clock edge
`define OPCE_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("opce: forbidden condition seen");

// condition that must hold in the cycle after a trigger
`define OPCE_NEXT(lbl, trig, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error("opce: expected follow-up missing");

`endif

FILE: rtl/opce_pkg.sv
package opce_pkg;

    localparam int DEF_MAX_OPEN = 16;
    localparam int DEF_MAX_PIX  = 64;
    localparam int HIT_Q_DEPTH  = 2;
    localparam int RES_Q_DEPTH  = 4;
    localparam int TOA_W        = 48;

    // configuration register indexes
    localparam logic [7:0] CFG_CLOSE_DELAY = 8'd0;
    localparam logic [7:0] CFG_JOIN_SPAN   = 8'd1;
    localparam logic [7:0] CFG_SIZE_LIMIT  = 8'd2;
    localparam logic [7:0] CFG_DROP_BIGGER = 8'd3;

    typedef struct packed {
        logic [7:0]       col;
        logic [7:0]       row;
        logic [9:0]       tot;
        logic [TOA_W-1:0] toa;
    } hit_t;

    typedef struct packed {
        logic [15:0] energy;
        logic [15:0] hit_total;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [31:0] close_delay;
        logic [31:0] join_span;
        logic [15:0] size_limit;
        logic        drop_bigger;
    } cfg_t;

    typedef struct packed {
        logic hit_pop;
        logic res_push;
        logic busy;
    } eng_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PIXRD,
        ST_PIXCMP,
        ST_MCRD,
        ST_MCWR,
        ST_MSRC,
        ST_MDST,
        ST_FINISH
    } eng_state_t;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

FILE: rtl/opce_fifo.sv
module opce_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     data_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = data_reg[rptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
            if (do_rd)
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            data_reg[wptr_reg] <= wdata;
    end

endmodule

FILE: rtl/opce_engine.sv
module opce_engine #(
    parameter int MAX_OPEN = opce_pkg::DEF_MAX_OPEN,
    parameter int MAX_PIX  = opce_pkg::DEF_MAX_PIX
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  opce_pkg::cfg_t        cfg,
    input  logic                  hit_empty,
    input  opce_pkg::hit_t        hit_head,
    input  logic                  res_full,
    output opce_pkg::res_t        res_data,
    output opce_pkg::eng_status_t status
);

    localparam int SW    = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
    localparam int NW    = $clog2(MAX_OPEN + 1);
    localparam int PW    = $clog2(MAX_PIX);
    localparam int JW    = $clog2(MAX_PIX + 1);
    localparam int AW    = SW + PW;
    localparam int DEPTH = 1 << AW;

    opce_pkg::eng_state_t state_reg, state_next;

    opce_pkg::hit_t hit_reg;
    logic [NW-1:0]  i_reg, i_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [JW-1:0]  j_reg, j_next;
    logic           added_reg, added_next;
    logic [SW-1:0]  tgt_reg, tgt_next;
    logic [15:0]    tcnt_reg, tcnt_next;
    logic           pend_valid_reg;
    opce_pkg::res_t pend_reg;
    logic [MAX_OPEN-1:0] used_reg;
    logic [SW-1:0]  order_reg [MAX_OPEN];

    // per-cluster records, indexed by physical slot
    logic [31:0]                box_reg  [MAX_OPEN];
    logic [opce_pkg::TOA_W-1:0] tmin_reg [MAX_OPEN];
    logic [opce_pkg::TOA_W-1:0] tmax_reg [MAX_OPEN];
    logic [15:0]                sum_reg  [MAX_OPEN];
    logic [15:0]                cnt_reg  [MAX_OPEN];

    // absorbed cluster during a merge
    logic [SW-1:0]              src_reg;
    logic [31:0]                tbox_reg;
    logic [opce_pkg::TOA_W-1:0] ttmin_reg;
    logic [opce_pkg::TOA_W-1:0] ttmax_reg;
    logic [15:0]                tsum_reg;
    logic [15:0]                tcount_reg;

    // pixel memory
    logic [15:0]   pix_mem [DEPTH];
    logic [15:0]   rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata;

    // control strobes
    logic hit_pop, res_push, load_pend, clr_pend;
    logic do_erase, do_add, do_alloc;
    logic [SW-1:0] erase_phys;

    // selected record
    logic [SW-1:0]              cur;
    logic [31:0]                c_box;
    logic [opce_pkg::TOA_W-1:0] c_tmin, c_tmax;
    logic [15:0]                c_sum, c_cnt;
    logic [JW-1:0]              c_sp, t_sd;
    logic [JW:0]                dst_pos;
    logic                       copy_ok;
    logic [opce_pkg::TOA_W:0]   gap, d1, d2;
    logic                       close_hit, span_ok, box_ok, nbr, drop;
    logic [SW-1:0]              free_idx;
    logic [8:0]                 hx, hy, px, py;

    assign cur    = (state_reg == opce_pkg::ST_MDST) ? tgt_reg : order_reg[i_reg[SW-1:0]];
    assign c_box  = box_reg[cur];
    assign c_tmin = tmin_reg[cur];
    assign c_tmax = tmax_reg[cur];
    assign c_sum  = sum_reg[cur];
    assign c_cnt  = cnt_reg[cur];

    // stored pixel counts
    assign c_sp    = (c_cnt >= 16'(MAX_PIX)) ? JW'(MAX_PIX) : c_cnt[JW-1:0];
    assign t_sd    = (tcnt_reg >= 16'(MAX_PIX)) ? JW'(MAX_PIX) : tcnt_reg[JW-1:0];
    assign dst_pos = {1'b0, t_sd} + {1'b0, j_reg};
    assign copy_ok = (j_reg < c_sp) && (dst_pos < (JW + 1)'(MAX_PIX));

    // time checks, signed differences
    assign gap = {1'b0, hit_reg.toa} - {1'b0, c_tmax};
    assign d1  = {1'b0, hit_reg.toa} - {1'b0, c_tmin};
    assign d2  = {1'b0, c_tmin} - {1'b0, hit_reg.toa};
    assign close_hit = $signed(gap) > $signed({17'd0, cfg.close_delay});
    assign span_ok   = !($signed(d1) > $signed({17'd0, cfg.join_span})) &&
                       !($signed(d2) > $signed({17'd0, cfg.join_span}));

    // bounding box check, no wrap at sensor edges
    assign hx = {1'b0, hit_reg.col};
    assign hy = {1'b0, hit_reg.row};
    assign box_ok = (hx + 9'd1 >= {1'b0, c_box[7:0]})   && (hx <= {1'b0, c_box[15:8]} + 9'd1) &&
                    (hy + 9'd1 >= {1'b0, c_box[23:16]}) && (hy <= {1'b0, c_box[31:24]} + 9'd1);

    // neighbour test against the pixel just read
    assign px  = {1'b0, rdata_reg[7:0]};
    assign py  = {1'b0, rdata_reg[15:8]};
    assign nbr = (hx + 9'd1 >= px) && (px + 9'd1 >= hx) && (hy + 9'd1 >= py) && (py + 9'd1 >= hy);

    // size filter
    assign drop = (cfg.size_limit != 16'd0) &&
                  ((!cfg.drop_bigger && (c_cnt < cfg.size_limit)) ||
                   (cfg.drop_bigger && (c_cnt > cfg.size_limit)));

    // lowest free physical slot
    always_comb
    begin
        free_idx = '0;
        for (int k = MAX_OPEN - 1; k >= 0; k--)
        begin
            if (!used_reg[k])
                free_idx = SW'(k);
        end
    end

    assign status.hit_pop  = hit_pop;
    assign status.res_push = res_push;
    assign status.busy     = (state_reg != opce_pkg::ST_IDLE);

    // state register and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= opce_pkg::ST_IDLE;
            i_reg          <= '0;
            n_reg          <= '0;
            j_reg          <= '0;
            added_reg      <= 1'b0;
            tgt_reg        <= '0;
            tcnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            used_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            n_reg     <= n_next;
            j_reg     <= j_next;
            added_reg <= added_next;
            tgt_reg   <= tgt_next;
            tcnt_reg  <= tcnt_next;
            if (load_pend)
                pend_valid_reg <= 1'b1;
            else if (clr_pend)
                pend_valid_reg <= 1'b0;
            if (do_erase)
                used_reg[erase_phys] <= 1'b0;
            if (do_alloc)
                used_reg[free_idx] <= 1'b1;
        end
    end

    // next state and strobes
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        added_next = added_reg;
        tgt_next   = tgt_reg;
        tcnt_next  = tcnt_reg;
        hit_pop    = 1'b0;
        res_push   = 1'b0;
        res_data   = pend_reg;
        load_pend  = 1'b0;
        clr_pend   = 1'b0;
        do_erase   = 1'b0;
        do_add     = 1'b0;
        do_alloc   = 1'b0;
        erase_phys = cur;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        case (state_reg)
            opce_pkg::ST_IDLE:
            begin
                if (!hit_empty)
                begin
                    hit_pop    = 1'b1;
                    i_next     = '0;
                    added_next = 1'b0;
                    state_next = opce_pkg::ST_SCAN;
                end
            end
            opce_pkg::ST_SCAN:
            begin
                if (i_reg == n_reg)
                    state_next = opce_pkg::ST_FINISH;
                else if (close_hit)
                begin
                    // closed cluster: hold it until the next one shows whether it is final
                    if (drop)
                        do_erase = 1'b1;
                    else if (!(pend_valid_reg && res_full))
                    begin
                        res_push      = pend_valid_reg;
                        res_data.last = 1'b0;
                        load_pend     = 1'b1;
                        do_erase      = 1'b1;
                    end
                    if (do_erase)
                        n_next = n_reg - NW'(1);
                end
                else if (span_ok && box_ok)
                begin
                    j_next     = '0;
                    state_next = opce_pkg::ST_PIXRD;
                end
                else
                    i_next = i_reg + NW'(1);
            end
            opce_pkg::ST_PIXRD:
            begin
                if (j_reg == c_sp)
                begin
                    i_next     = i_reg + NW'(1);
                    state_next = opce_pkg::ST_SCAN;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {cur, j_reg[PW-1:0]};
                    state_next = opce_pkg::ST_PIXCMP;
                end
            end
            opce_pkg::ST_PIXCMP:
            begin
                if (!nbr)
                begin
                    j_next     = j_reg + JW'(1);
                    state_next = opce_pkg::ST_PIXRD;
                end
                else if (added_reg)
                begin
                    j_next     = '0;
                    state_next = opce_pkg::ST_MCRD;
                end
                else
                begin
                    // first match takes the hit
                    do_add     = 1'b1;
                    mem_we     = (c_cnt < 16'(MAX_PIX));
                    mem_waddr  = {cur, c_cnt[PW-1:0]};
                    mem_wdata  = {hit_reg.row, hit_reg.col};
                    tgt_next   = cur;
                    tcnt_next  = opce_pkg::sat_add16(c_cnt, 16'd1);
                    added_next = 1'b1;
                    i_next     = i_reg + NW'(1);
                    state_next = opce_pkg::ST_SCAN;
                end
            end
            opce_pkg::ST_MCRD:
            begin
                if (copy_ok)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {cur, j_reg[PW-1:0]};
                    state_next = opce_pkg::ST_MCWR;
                end
                else
                    state_next = opce_pkg::ST_MSRC;
            end
            opce_pkg::ST_MCWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {tgt_reg, dst_pos[PW-1:0]};
                mem_wdata  = rdata_reg;
                j_next     = j_reg + JW'(1);
                state_next = opce_pkg::ST_MCRD;
            end
            opce_pkg::ST_MSRC:
            begin
                state_next = opce_pkg::ST_MDST;
            end
            opce_pkg::ST_MDST:
            begin
                tcnt_next  = opce_pkg::sat_add16(tcnt_reg, tcount_reg);
                do_erase   = 1'b1;
                erase_phys = src_reg;
                n_next     = n_reg - NW'(1);
                state_next = opce_pkg::ST_SCAN;
            end
            opce_pkg::ST_FINISH:
            begin
                if (!(pend_valid_reg && res_full))
                begin
                    res_push      = pend_valid_reg;
                    res_data.last = 1'b1;
                    clr_pend      = 1'b1;
                    if (!added_reg && (n_reg < NW'(MAX_OPEN)))
                    begin
                        do_alloc  = 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = {free_idx, PW'(0)};
                        mem_wdata = {hit_reg.row, hit_reg.col};
                        n_next    = n_reg + NW'(1);
                    end
                    state_next = opce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = opce_pkg::ST_IDLE;
            end
        endcase
    end

    // hit, pending result, order list and cluster records
    always_ff @(posedge clk)
    begin
        if (hit_pop)
            hit_reg <= hit_head;
        if (load_pend)
        begin
            pend_reg.energy    <= c_sum;
            pend_reg.hit_total <= c_cnt;
            pend_reg.last      <= 1'b0;
        end
        if (do_erase)
        begin
            for (int k = 0; k < MAX_OPEN - 1; k++)
            begin
                if ((NW'(k) >= i_reg) && (NW'(k + 1) < n_reg))
                    order_reg[k] <= order_reg[k + 1];
            end
        end
        if (do_add)
        begin
            if (hit_reg.col < c_box[7:0])   box_reg[cur][7:0]   <= hit_reg.col;
            if (hit_reg.col > c_box[15:8])  box_reg[cur][15:8]  <= hit_reg.col;
            if (hit_reg.row < c_box[23:16]) box_reg[cur][23:16] <= hit_reg.row;
            if (hit_reg.row > c_box[31:24]) box_reg[cur][31:24] <= hit_reg.row;
            if (hit_reg.toa < c_tmin) tmin_reg[cur] <= hit_reg.toa;
            if (hit_reg.toa > c_tmax) tmax_reg[cur] <= hit_reg.toa;
            sum_reg[cur] <= c_sum + {6'd0, hit_reg.tot};
            cnt_reg[cur] <= opce_pkg::sat_add16(c_cnt, 16'd1);
        end
        if (state_reg == opce_pkg::ST_MSRC)
        begin
            src_reg    <= cur;
            tbox_reg   <= c_box;
            ttmin_reg  <= c_tmin;
            ttmax_reg  <= c_tmax;
            tsum_reg   <= c_sum;
            tcount_reg <= c_cnt;
        end
        if (state_reg == opce_pkg::ST_MDST)
        begin
            if (tbox_reg[7:0]   < c_box[7:0])   box_reg[cur][7:0]   <= tbox_reg[7:0];
            if (tbox_reg[15:8]  > c_box[15:8])  box_reg[cur][15:8]  <= tbox_reg[15:8];
            if (tbox_reg[23:16] < c_box[23:16]) box_reg[cur][23:16] <= tbox_reg[23:16];
            if (tbox_reg[31:24] > c_box[31:24]) box_reg[cur][31:24] <= tbox_reg[31:24];
            if (ttmin_reg < c_tmin) tmin_reg[cur] <= ttmin_reg;
            if (ttmax_reg > c_tmax) tmax_reg[cur] <= ttmax_reg;
            sum_reg[cur] <= c_sum + tsum_reg;
            cnt_reg[cur] <= opce_pkg::sat_add16(c_cnt, tcount_reg);
        end
        if (do_alloc)
        begin
            order_reg[n_reg[SW-1:0]] <= free_idx;
            box_reg[free_idx]  <= {hit_reg.row, hit_reg.row, hit_reg.col, hit_reg.col};
            tmin_reg[free_idx] <= hit_reg.toa;
            tmax_reg[free_idx] <= hit_reg.toa;
            sum_reg[free_idx]  <= {6'd0, hit_reg.tot};
            cnt_reg[free_idx]  <= 16'd1;
        end
    end

    // pixel memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pix_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= pix_mem[mem_raddr];
    end

endmodule

FILE: rtl/online_pixel_cluster_energy_core.sv
// channel | direction | handshake         | payload
// hit     | in        | push / full       | col, row, tot, toa
// result  | out       | pop / empty       | energy, hit_total, last
// config  | in        | cfg_valid / ready | cfg_index, cfg_data
//
// a hit visits each open cluster in turn; a cluster that passes the time
// and box checks has its stored pixels read and compared one at a time;
// a merge copies each pixel through the registered pixel memory read, then folds in the record
// reset clears the open-cluster table and loads the register defaults
// a full result queue stalls the cluster engine; the hit queue takes up to two more hits
`include "online_pixel_cluster_energy_core_defines.svh"

module online_pixel_cluster_energy_core #(
    parameter int MAX_OPEN_CLUSTERS  = opce_pkg::DEF_MAX_OPEN,
    parameter int MAX_CLUSTER_PIXELS = opce_pkg::DEF_MAX_PIX
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  opce_pkg::hit_t hit,
    output logic           empty,
    input  logic           pop,
    output opce_pkg::res_t result,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    opce_pkg::cfg_t        cfg_reg;
    opce_pkg::hit_t        hit_head;
    opce_pkg::res_t        res_data;
    opce_pkg::eng_status_t eng_st;
    logic                  hit_empty;
    logic                  res_full;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.close_delay <= 32'd1000;
            cfg_reg.join_span   <= 32'd1000;
            cfg_reg.size_limit  <= 16'd0;
            cfg_reg.drop_bigger <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                opce_pkg::CFG_CLOSE_DELAY: cfg_reg.close_delay <= cfg_data;
                opce_pkg::CFG_JOIN_SPAN:   cfg_reg.join_span   <= cfg_data;
                opce_pkg::CFG_SIZE_LIMIT:  cfg_reg.size_limit  <= cfg_data[15:0];
                opce_pkg::CFG_DROP_BIGGER: cfg_reg.drop_bigger <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // front: hit queue
    opce_fifo #(
        .W     ($bits(opce_pkg::hit_t)),
        .DEPTH (opce_pkg::HIT_Q_DEPTH)
    ) u_hit_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (hit),
        .rd    (eng_st.hit_pop),
        .rdata (hit_head),
        .full  (full),
        .empty (hit_empty)
    );

    // back: cluster engine
    opce_engine #(
        .MAX_OPEN (MAX_OPEN_CLUSTERS),
        .MAX_PIX  (MAX_CLUSTER_PIXELS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .hit_empty (hit_empty),
        .hit_head  (hit_head),
        .res_full  (res_full),
        .res_data  (res_data),
        .status    (eng_st)
    );

    // result queue
    opce_fifo #(
        .W     ($bits(opce_pkg::res_t)),
        .DEPTH (opce_pkg::RES_Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (eng_st.res_push),
        .wdata (res_data),
        .rd    (pop),
        .rdata (result),
        .full  (res_full),
        .empty (empty)
    );

    `OPCE_NEVER(a_res_overflow, eng_st.res_push && res_full)
    `OPCE_NEVER(a_hit_underflow, eng_st.hit_pop && hit_empty)
    `OPCE_NEVER(a_pop_push_excl, eng_st.hit_pop && eng_st.res_push)
    `OPCE_NEXT(a_pop_starts_work, eng_st.hit_pop, eng_st.busy)

endmodule
